@@ sv/pcpa_pkg.sv @@
// Shared types and constants for the per-CPU page free-list allocator.
// Used by every module of the block; has no dependencies of its own.
package pcpa_pkg;

    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 16;
    localparam int CPU_IN_W = 3;
    localparam int CPU_W   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PG_W    = $clog2(PAGE_COUNT);
    localparam int CFG_W   = 1;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] TOP_RESET  = 32'h0800_0000;

    localparam logic [CFG_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_W-1:0] CFG_TOP  = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              own;   // requester has a list of its own
        logic [CPU_W-1:0]  cpu;
        logic [PG_W-1:0]   page;
    } t_cmd;

endpackage

@@ sv/per_cpu_page_free_list_allocator_top.sv @@
// Top level of the per-CPU page free-list allocator.
// Instantiates pcpa_front, pcpa_queue and pcpa_back; depends on pcpa_pkg.
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) with a request
// type, a CPU index and, for a free, the page byte address. Each request gives
// exactly one result on the output channel (o_out_valid / i_out_stall) with a
// status and, for a successful allocate, the page byte address.
// A transfer happens on a rising edge where valid is high and stall is low.
// The front end checks free addresses for alignment and against the base and top registers and
// the page count, and places a classified command into a two-entry queue. The list engine takes one
// command at a time. A free, a rejected free or an out-of-memory allocate
// completes in the state in which it is taken; a successful allocate also
// passes through the pop state, since the next-page memory read at the list
// head is registered before the head can move. Results are in order. When the
// receiver stalls, the result register holds, the engine stops, the queue fills
// and the input stall rises. The bound registers are written on the plain config
// port (index 0 base, index 1 top); the user must write them only while the
// block is idle, as the block itself does not enforce it.
// Synchronous reset empties all lists and the queue; the next-page memory is not
// cleared because every entry is written by a free before it can be read.
module per_cpu_page_free_list_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcpa_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [pcpa_pkg::CPU_IN_W-1:0] i_cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]   i_page_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [pcpa_pkg::ADDR_W-1:0]   o_alloc_addr
);

    logic           w_push;
    logic           w_q_full;
    logic           w_q_valid;
    logic           w_take;
    pcpa_pkg::t_cmd w_cmd_in;
    pcpa_pkg::t_cmd w_cmd_out;

    assign o_in_stall = w_q_full;

    pcpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_cpu_id    (i_cpu_id),
        .i_page_addr (i_page_addr),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    pcpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_take),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    pcpa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_cmd_out),
        .o_cmd_take   (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_alloc_addr (o_alloc_addr)
    );

    // A result that is not a successful allocate never carries an address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pcpa_pkg::ST_OK && o_alloc_addr != '0) |-> 1'b0)
        else $error("non-ok result carries a page address");

    // Only the three defined status codes are ever produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == pcpa_pkg::ST_OK || o_status == pcpa_pkg::ST_OOM
                         || o_status == pcpa_pkg::ST_BAD))
        else $error("undefined status code on output");

    // Nothing can be presented in the cycle after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // The engine never takes a command from an empty queue.
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_q_valid)
        else $error("command taken from empty queue");

endmodule

@@ sv/pcpa_front.sv @@
// Front end: holds the address bound registers, checks and classifies requests.
// Depends on pcpa_pkg.
module pcpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcpa_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_req_type,
    input  logic [pcpa_pkg::CPU_IN_W-1:0] i_cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]   i_page_addr,
    input  logic                          i_q_full,
    output logic                          o_push,
    output pcpa_pkg::t_cmd                o_cmd
);

    logic [pcpa_pkg::ADDR_W-1:0] r_base;
    logic [pcpa_pkg::ADDR_W-1:0] r_top;
    logic                        w_own;
    logic                        w_bad;
    logic [pcpa_pkg::ADDR_W-1:0] w_pg_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= pcpa_pkg::BASE_RESET;
            r_top  <= pcpa_pkg::TOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcpa_pkg::CFG_BASE: r_base <= i_cfg_data;
                pcpa_pkg::CFG_TOP:  r_top  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_pg_full = i_page_addr >> pcpa_pkg::PAGE_SHIFT;
        w_own     = (32'(i_cpu_id) < 32'(pcpa_pkg::CPU_COUNT));
        w_bad     = (i_page_addr[pcpa_pkg::PAGE_SHIFT-1:0] != '0)
                    || (i_page_addr < r_base)
                    || (i_page_addr >= r_top)
                    || (w_pg_full >= 32'(pcpa_pkg::PAGE_COUNT))
                    || !w_own;

        o_cmd.own  = w_own;
        o_cmd.cpu  = pcpa_pkg::CPU_W'(i_cpu_id);
        o_cmd.page = pcpa_pkg::PG_W'(w_pg_full);
        if (i_req_type == pcpa_pkg::REQ_ALLOC) begin
            o_cmd.op = pcpa_pkg::OP_POP;
        end else if (w_bad) begin
            o_cmd.op = pcpa_pkg::OP_BAD;
        end else begin
            o_cmd.op = pcpa_pkg::OP_PUSH;
        end
    end

    assign o_push = i_in_valid && !i_q_full;

endmodule

@@ sv/pcpa_queue.sv @@
// Short command queue that decouples the front end from the list engine.
// Depends on pcpa_pkg.
module pcpa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcpa_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pcpa_pkg::t_cmd o_cmd
);

    pcpa_pkg::t_cmd                r_mem [pcpa_pkg::Q_DEPTH];
    logic [pcpa_pkg::Q_PW-1:0]     r_wp;
    logic [pcpa_pkg::Q_PW-1:0]     r_rp;
    logic [pcpa_pkg::Q_CW-1:0]     r_cnt;

    assign o_full  = (r_cnt == pcpa_pkg::Q_CW'(pcpa_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == pcpa_pkg::Q_PW'(pcpa_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == pcpa_pkg::Q_PW'(pcpa_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ sv/pcpa_back.sv @@
// List engine: per-CPU heads and counts, the next-page memory and the result register.
// Depends on pcpa_pkg.
module pcpa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  pcpa_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_take,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [pcpa_pkg::ADDR_W-1:0]   o_alloc_addr
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state                          r_state;
    logic [pcpa_pkg::PG_W-1:0]       r_head  [pcpa_pkg::CPU_COUNT];
    logic [pcpa_pkg::CNT_W-1:0]      r_count [pcpa_pkg::CPU_COUNT];
    logic [pcpa_pkg::PG_W-1:0]       r_next  [pcpa_pkg::PAGE_COUNT];
    logic [pcpa_pkg::PG_W-1:0]       r_rd;
    logic [pcpa_pkg::CPU_W-1:0]      r_tgt;
    logic [pcpa_pkg::PG_W-1:0]       r_pg;
    logic                            r_out_valid;
    logic [1:0]                      r_status;
    logic [pcpa_pkg::ADDR_W-1:0]     r_addr;

    logic                            w_out_free;
    logic                            w_take;
    logic                            w_any;
    logic [pcpa_pkg::CPU_W-1:0]      w_tgt;
    logic                            w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_take     = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign o_cmd_take = w_take;

    // A result is loaded when a pop completes or when a command finishes in
    // the cycle it is taken.
    assign w_res = (r_state == S_POP)
                   || (w_take && !(i_cmd.op == pcpa_pkg::OP_POP && w_any));

    // Own list first, otherwise the lowest-numbered CPU holding pages.
    always_comb begin
        w_any = 1'b0;
        w_tgt = '0;
        for (int i = pcpa_pkg::CPU_COUNT - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_any = 1'b1;
                w_tgt = pcpa_pkg::CPU_W'(i);
            end
        end
        if (i_cmd.own && r_count[i_cmd.cpu] != '0) begin
            w_tgt = i_cmd.cpu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_cmd.op == pcpa_pkg::OP_PUSH) begin
            r_next[i_cmd.page] <= r_head[i_cmd.cpu];
        end
        if (w_take && i_cmd.op == pcpa_pkg::OP_POP) begin
            r_rd <= r_next[r_head[w_tgt]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < pcpa_pkg::CPU_COUNT; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (w_res) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (i_cmd.op)
                            pcpa_pkg::OP_PUSH: begin
                                r_head[i_cmd.cpu]  <= i_cmd.page;
                                r_count[i_cmd.cpu] <= r_count[i_cmd.cpu] + 1'b1;
                                r_status           <= pcpa_pkg::ST_OK;
                                r_addr             <= '0;
                            end
                            pcpa_pkg::OP_POP: begin
                                if (w_any) begin
                                    r_tgt   <= w_tgt;
                                    r_pg    <= r_head[w_tgt];
                                    r_state <= S_POP;
                                end else begin
                                    r_status    <= pcpa_pkg::ST_OOM;
                                    r_addr      <= '0;
                                end
                            end
                            default: begin
                                r_status    <= pcpa_pkg::ST_BAD;
                                r_addr      <= '0;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    // The result register was emptied when this pop started.
                    r_head[r_tgt]  <= r_rd;
                    r_count[r_tgt] <= r_count[r_tgt] - 1'b1;
                    r_status       <= pcpa_pkg::ST_OK;
                    r_addr         <= pcpa_pkg::ADDR_W'(r_pg) << pcpa_pkg::PAGE_SHIFT;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_alloc_addr = r_addr;

endmodule
